@@ sv/hoa_pkg.sv @@
// hoa_pkg: shared types and constants for the hann overlap-add synthesis unit
// no dependencies; used by hoa_div and hann_overlap_add_synthesis_unit
package hoa_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = 6;
  localparam int SUM_W      = 40;
  localparam int WSUM_W     = 24;
  localparam int WIN_W      = 15;
  localparam int HOP_W      = 15;
  localparam int FRAME_LEN_DEF = 64;
  localparam logic [HOP_W-1:0] HOP_RESET = 15'd4096;
  localparam logic [6:0] HOP_MAX = 7'd64;

  typedef struct packed {
    logic               action;
    logic signed [15:0] sample_in;
    logic [15:0]        time_ratio;
  } hoa_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               last_of_run;
    logic               clipped;
  } hoa_out_t;

  // one ring entry: running sum and weight sum side by side
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [WSUM_W-1:0]       wsum;
  } hoa_word_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               sat;
  } hoa_div_res_t;

  localparam logic [0:0] ACT_SAMPLE = 1'b0;
  localparam logic [0:0] ACT_FLUSH  = 1'b1;

endpackage

@@ sv/hoa_ram.sv @@
// hoa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module hoa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/hoa_div.sv @@
// hoa_div: rounded, saturating sum / weight-sum divider, two quotient bits a cycle
// depends on hoa_pkg
module hoa_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [hoa_pkg::SUM_W-1:0] sum,
  input  logic [hoa_pkg::WSUM_W-1:0]       wsum,
  output logic                             done,
  output logic                             busy,
  output hoa_pkg::hoa_div_res_t            res
);
  import hoa_pkg::*;

  localparam int NUM_W = SUM_W + 2;
  localparam int DEN_W = WSUM_W + 1;

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [15:0]      q_r, q_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;
  logic             big_r, big_nxt;

  logic [SUM_W-1:0] mag;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] rem_t;
  logic [NUM_W-1:0] sub_t;
  logic [15:0]      q_t;
  logic [3:0]       sh;

  always_comb begin
    mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    // rounding: (2|s| + w) / (2w)
    num = {1'b0, mag, 1'b0} + NUM_W'(wsum);
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    big_nxt  = big_r;
    rem_t    = rem_r;
    q_t      = q_r;
    sh       = 4'd0;
    sub_t    = '0;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = {wsum, 1'b0};
      q_nxt    = '0;
      neg_nxt  = sum[SUM_W-1];
      zero_nxt = (wsum == '0);
      big_nxt  = (num >= {1'b0, wsum, 1'b0, 16'd0});
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      for (int b = 0; b < 2; b++) begin
        sh = 4'(4'd15 - {cnt_r, 1'b0} - 4'(b));
        sub_t = NUM_W'(den_r) << sh;
        if (rem_t >= sub_t) begin
          rem_t = rem_t - sub_t;
          q_t[sh] = 1'b1;
        end
      end
      rem_nxt = rem_t;
      q_nxt   = q_t;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    big_r  <= big_nxt;
  end

  always_comb begin
    res.value = '0;
    res.sat   = 1'b0;
    if (zero_r) begin
      res.value = '0;
    end else if (neg_r) begin
      if (big_r || q_r > 16'd32768) begin
        res.value = 16'sh8000;
        res.sat   = 1'b1;
      end else begin
        res.value = 16'(-q_r);
      end
    end else begin
      if (big_r || q_r > 16'd32767) begin
        res.value = 16'sh7fff;
        res.sat   = 1'b1;
      end else begin
        res.value = q_r;
      end
    end
  end

  assign done = done_r;
  assign busy = run_r;

endmodule

@@ sv/hann_overlap_add_synthesis_unit.sv @@
// hann_overlap_add_synthesis_unit: windowed overlap-add with normalized output
// depends on hoa_pkg, hoa_ram, hoa_div
//
//   channel | ports                      | word
//   input   | in_valid in_stall in_data  | hoa_in_t: action, sample_in, time_ratio
//   output  | out_valid out_stall out_data | hoa_out_t: sample_out, last_of_run, clipped
//   config  | cfg_we cfg_wdata           | base hop, q8
//
// a frame sample is a ring read, then multiply-accumulate and write back
// each emitted word is a ring read, a load and clear, the 2-bit-a-cycle divider,
// then hand-off of the word to the output register
// a flush emits FRAME_LEN words; a frame's last sample emits its hop count
// reset is synchronous; ring contents read as zero through per-entry valid bits
// out_stall only holds the output register; the sequencer waits on it only for a full slot
module hann_overlap_add_synthesis_unit #(
  parameter int FRAME_LEN = hoa_pkg::FRAME_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hoa_pkg::hoa_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hoa_pkg::hoa_out_t           out_data,
  input  logic                        cfg_we,
  input  logic [hoa_pkg::HOP_W-1:0]   cfg_wdata
);
  import hoa_pkg::*;

  localparam logic [63:0] N1     = 64'(FRAME_LEN - 1);
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [RING_AW-1:0] LAST_IDX = RING_AW'(FRAME_LEN - 1);
  localparam logic [6:0] RUN_FLUSH = 7'(FRAME_LEN);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_ERD  = 3'd2;
  localparam logic [2:0] S_ELD  = 3'd3;
  localparam logic [2:0] S_EDIV = 3'd4;
  localparam logic [2:0] S_EOUT = 3'd5;

  // window table: sin^2 by a truncated taylor series in q30, mirrored index
  function automatic logic [RING_DEPTH*WIN_W-1:0] build_rom();
    logic [RING_DEPTH*WIN_W-1:0] r;
    logic [63:0] j, x, x2, term, s, w;
    longint sg;
    r = '0;
    for (int i = 0; i < FRAME_LEN; i++) begin
      j  = (64'(i) <= N1 - 64'(i)) ? 64'(i) : N1 - 64'(i);
      x  = (j * PI_Q30 + N1 / 2) / N1;
      x2 = (x * x) >> 30;
      sg = longint'(x);
      term = ((x * x2) >> 30) / 6;
      sg = sg - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sg = sg + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sg = sg - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sg = sg + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sg = sg - longint'(term);
      s = (sg < 0) ? 64'd0 : 64'(sg);
      if (s > (64'd1 << 31)) s = 64'd1 << 31;
      w = (s * s + (64'd1 << 45)) >> 46;
      if (w > 64'd16384) w = 64'd16384;
      r[i*WIN_W +: WIN_W] = w[WIN_W-1:0];
    end
    return r;
  endfunction

  localparam logic [RING_DEPTH*WIN_W-1:0] HANN_ROM = build_rom();

  logic [2:0]         state_r, state_nxt;
  logic [RING_AW-1:0] base_r, base_nxt;
  logic [RING_AW-1:0] sidx_r, sidx_nxt;
  logic [7:0]         tf_r, tf_nxt;
  logic [HOP_W-1:0]   hop_r;
  hoa_in_t            in_r, in_nxt;
  logic [RING_AW-1:0] pos_r, pos_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic [RING_AW-1:0] k_r, k_nxt;
  logic               clip_r, clip_nxt;
  logic               flush_r, flush_nxt;
  logic [RING_DEPTH-1:0] valid_r, valid_nxt;
  logic               rvld_r;
  logic               out_valid_r, out_valid_nxt;
  hoa_out_t           out_data_r, out_data_nxt;

  logic               in_acc;
  logic               mem_we;
  logic [RING_AW-1:0] mem_waddr, mem_raddr, eaddr;
  hoa_word_t          mem_wdata, mem_rdata, cur;
  logic               div_start, div_done, div_busy;
  hoa_div_res_t       div_res;

  logic [WIN_W-1:0]         win;
  logic signed [31:0]       prod;
  logic signed [SUM_W:0]    acc;
  logic [WSUM_W:0]          wacc;
  logic [30:0]              hop_prod;
  logic [19:0]              total;
  logic                     out_free;
  logic                     run_last;

  hoa_ram #(
    .WIDTH ($bits(hoa_word_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hoa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (cur.sum),
    .wsum  (cur.wsum),
    .done  (div_done),
    .busy  (div_busy),
    .res   (div_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign eaddr    = base_r + k_r;
  assign out_free = !out_valid_r || !out_stall;
  assign run_last = ({1'b0, k_r} + 7'd1 == cnt_r);

  always_comb begin
    cur = rvld_r ? mem_rdata : '0;
    win = HANN_ROM[sidx_r*WIN_W +: WIN_W];
    prod = in_r.sample_in * $signed({1'b0, win});
    acc  = (SUM_W+1)'(cur.sum) + (SUM_W+1)'(prod);
    wacc = {1'b0, cur.wsum} + (WSUM_W+1)'(win);
    hop_prod = hop_r * in_r.time_ratio;
    total = {12'd0, tf_r} + {1'b0, hop_prod[30:12]};
  end

  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    sidx_nxt  = sidx_r;
    tf_nxt    = tf_r;
    in_nxt    = in_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    clip_nxt  = clip_r;
    flush_nxt = flush_r;
    valid_nxt = valid_r;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = '0;
    mem_raddr = eaddr;
    div_start = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        mem_raddr = base_r + sidx_r;
        if (in_acc) begin
          in_nxt = in_data;
          if (in_data.action == ACT_FLUSH) begin
            cnt_nxt   = RUN_FLUSH;
            k_nxt     = '0;
            clip_nxt  = 1'b0;
            flush_nxt = 1'b1;
            state_nxt = S_ERD;
          end else begin
            pos_nxt   = base_r + sidx_r;
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        valid_nxt[pos_r] = 1'b1;
        if (acc[SUM_W] != acc[SUM_W-1]) begin
          mem_wdata.sum = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          mem_wdata.sum = acc[SUM_W-1:0];
        end
        mem_wdata.wsum = wacc[WSUM_W] ? '1 : wacc[WSUM_W-1:0];
        if (sidx_r == LAST_IDX) begin
          sidx_nxt  = '0;
          k_nxt     = '0;
          flush_nxt = 1'b0;
          if (total[19:8] > 12'(HOP_MAX)) begin
            cnt_nxt  = HOP_MAX;
            tf_nxt   = '0;
            clip_nxt = 1'b1;
          end else begin
            cnt_nxt  = total[14:8];
            tf_nxt   = total[7:0];
            clip_nxt = 1'b0;
          end
          state_nxt = (total[19:8] == '0) ? S_IDLE : S_ERD;
        end else begin
          sidx_nxt  = sidx_r + RING_AW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_ERD: begin
        mem_raddr = eaddr;
        state_nxt = S_ELD;
      end
      S_ELD: begin
        // entry is final: start the divide and clear it in the same cycle
        div_start = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = eaddr;
        mem_wdata = '0;
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        if (div_done) begin
          state_nxt = S_EOUT;
        end
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.sample_out  = div_res.value;
          out_data_nxt.last_of_run = run_last;
          out_data_nxt.clipped     = clip_r || div_res.sat;
          if (run_last) begin
            if (flush_r) begin
              base_nxt = '0;
              sidx_nxt = '0;
              tf_nxt   = '0;
            end else begin
              base_nxt = base_r + cnt_r[RING_AW-1:0];
            end
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + RING_AW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      sidx_r      <= '0;
      tf_r        <= '0;
      hop_r       <= HOP_RESET;
      cnt_r       <= '0;
      k_r         <= '0;
      clip_r      <= 1'b0;
      flush_r     <= 1'b0;
      valid_r     <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      sidx_r      <= sidx_nxt;
      tf_r        <= tf_nxt;
      if (cfg_we) begin
        hop_r <= cfg_wdata;
      end
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      clip_r      <= clip_nxt;
      flush_r     <= flush_nxt;
      valid_r     <= valid_nxt;
      rvld_r      <= valid_r[mem_raddr];
      out_valid_r <= out_valid_nxt;
    end
    in_r       <= in_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("divider running while sequencer idle");

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERD) |-> (({1'b0, k_r} < cnt_r) && (cnt_r <= HOP_MAX)))
    else $error("emit index outside run");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_EDIV))
    else $error("divider finished outside wait state");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ELD) |=> (state_r == S_EDIV) && div_busy)
    else $error("divide not started on entry load");

endmodule

@@ tb/tb_hann_overlap_add_synthesis_unit.sv @@
// tb_hann_overlap_add_synthesis_unit: streaming check of the hann overlap-add unit
// depends on hoa_pkg and hann_overlap_add_synthesis_unit; self-contained predictor
module tb_hann_overlap_add_synthesis_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hoa_pkg::*;

  localparam int FLEN = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hoa_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hoa_out_t out_data;
  logic cfg_we = 1'b0;
  logic [HOP_W-1:0] cfg_wdata = '0;

  hann_overlap_add_synthesis_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [63:0] acc_ring [FLEN];
  logic [31:0] wt_ring [FLEN];
  logic [31:0] hann_w [FLEN];
  int unsigned base_pos, frame_pos, frac_q8;
  logic [HOP_W-1:0] hop_q8;

  hoa_in_t pending_words[$];
  hoa_out_t expected_words[$];
  int errors = 0;
  bit hold_off = 1'b0;

  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2, term;
    longint s;
    x2 = (x * x) >> 30;
    term = x;
    s = x;
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s -= term; else s += term;
    end
    return (s < 0) ? 0 : s;
  endfunction

  task automatic build_window();
    longint unsigned n1, j, x, s, w;
    n1 = FLEN - 1;
    for (int i = 0; i < FLEN; i++) begin
      j = (i <= n1 - i) ? i : n1 - i;
      x = (j * 64'd3373259426 + n1 / 2) / n1;
      s = sine_q30(x);
      if (s > (64'd1 << 31)) s = 64'd1 << 31;
      w = (s * s + (64'd1 << 45)) >> 46;
      hann_w[i] = (w > 16384) ? 32'd16384 : 32'(w);
    end
  endtask

  task automatic clear_model();
    for (int i = 0; i < FLEN; i++) begin
      acc_ring[i] = 0;
      wt_ring[i] = 0;
    end
    base_pos = 0;
    frame_pos = 0;
    frac_q8 = 0;
  endtask

  task automatic emit_finished(int unsigned count, bit hop_sat);
    int unsigned p;
    longint unsigned mag, q;
    hoa_out_t r;
    bit sat;
    for (int unsigned k = 0; k < count; k++) begin
      p = (base_pos + k) % FLEN;
      sat = 1'b0;
      if (wt_ring[p] == 0) begin
        r.sample_out = '0;
      end else begin
        mag = (acc_ring[p] < 0) ? -acc_ring[p] : acc_ring[p];
        q = (2 * mag + wt_ring[p]) / (2 * longint'(wt_ring[p]));
        if (acc_ring[p] < 0) begin
          if (q > 32768) begin sat = 1'b1; r.sample_out = -16'sd32768; end
          else r.sample_out = 16'(-q);
        end else begin
          if (q > 32767) begin sat = 1'b1; r.sample_out = 16'sd32767; end
          else r.sample_out = 16'(q);
        end
      end
      r.last_of_run = (k + 1 == count);
      r.clipped = hop_sat | sat;
      expected_words.push_back(r);
      acc_ring[p] = 0;
      wt_ring[p] = 0;
    end
  endtask

  task automatic predict_word(hoa_in_t w);
    int unsigned p, adv, total;
    longint sacc;
    bit hop_sat;
    if (w.action == ACT_FLUSH) begin
      emit_finished(FLEN, 1'b0);
      base_pos = 0;
      frame_pos = 0;
      frac_q8 = 0;
      return;
    end
    p = (base_pos + frame_pos) % FLEN;
    sacc = acc_ring[p] + longint'(w.sample_in) * longint'(hann_w[frame_pos]);
    if (sacc > 64'sd549755813887) sacc = 64'sd549755813887;
    if (sacc < -64'sd549755813888) sacc = -64'sd549755813888;
    acc_ring[p] = sacc;
    wt_ring[p] = (wt_ring[p] + hann_w[frame_pos] > 32'hFFFFFF) ? 32'hFFFFFF
                 : wt_ring[p] + hann_w[frame_pos];
    if (frame_pos + 1 < FLEN) begin
      frame_pos++;
      return;
    end
    frame_pos = 0;
    total = frac_q8 + 32'((longint'(hop_q8) * w.time_ratio) >> 12);
    adv = total >> 8;
    frac_q8 = total & 8'hFF;
    hop_sat = 1'b0;
    if (adv > 64) begin
      adv = 64;
      frac_q8 = 0;
      hop_sat = 1'b1;
    end
    emit_finished(adv, hop_sat);
    base_pos = (base_pos + adv) % FLEN;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver: pops pending words, random gaps
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_word(in_data);
        void'(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_data <= pending_words[0];
        in_valid <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  int ostall = 0;
  always @(posedge clk) begin
    hoa_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_data.sample_out, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_data.sample_out !== want.sample_out)
            report_mismatch("sample_out", out_data.sample_out, want.sample_out);
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
          if (out_data.clipped !== want.clipped)
            report_mismatch("clipped", out_data.clipped, want.clipped);
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (ostall > 0) begin
        ostall <= ostall - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        ostall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic hoa_in_t frame_word(logic signed [15:0] s, logic [15:0] r);
    hoa_in_t w;
    w.action = ACT_SAMPLE;
    w.sample_in = s;
    w.time_ratio = r;
    return w;
  endfunction

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_hop(logic [HOP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hop_q8 = v;
  endtask

  // one frame; kind picks random, max, min or small samples
  task automatic queue_frame(logic [15:0] ratio, int kind);
    logic signed [15:0] s;
    for (int i = 0; i < FLEN; i++) begin
      case (kind)
        0: s = 16'($urandom);
        1: s = 16'sd32767;
        2: s = -16'sd32768;
        default: s = 16'($urandom_range(0, 200) - 100);
      endcase
      pending_words.push_back(frame_word(s, (i == FLEN - 1) ? ratio : 16'($urandom)));
    end
  endtask

  task automatic queue_flush();
    hoa_in_t w;
    w.action = ACT_FLUSH;
    w.sample_in = 16'($urandom);
    w.time_ratio = 16'($urandom);
    pending_words.push_back(w);
  endtask

  logic [HOP_W-1:0] hop_set [5] = '{15'd4096, 15'd0, 15'd16384, 15'd32767, 15'd2500};
  initial begin
    hoa_in_t w;
    int n_extra;
    logic [15:0] ratio;
    build_window();
    clear_model();
    hop_q8 = HOP_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // saturated hop with extreme samples, under a long receiver hold-off
    // while the sender keeps offering the next frame's start and a flush
    hold_off = 1'b1;
    queue_frame(16'hFFFF, 1);
    for (int i = 0; i < 3; i++)
      pending_words.push_back(frame_word(16'($urandom), 16'($urandom)));
    queue_flush();
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    wait_idle();
    // one frame under a random hop, then a mid-frame flush
    write_hop(hop_set[$urandom_range(0, 4)]);
    ratio = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(1, 16'h2000));
    queue_frame(ratio, $urandom_range(0, 3));
    n_extra = $urandom_range(1, 4);
    for (int i = 0; i < n_extra; i++) begin
      w = frame_word(16'($urandom), 16'($urandom));
      w.action = $urandom_range(0, 5) == 0;
      pending_words.push_back(w);
    end
    queue_flush();
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
